// ===== sv/gmu_pkg.sv =====
// Shared types and constants for the gradient magnitude unit.
// No dependencies; imported by every module of the block.
package gmu_pkg;

    // norm selector codes
    localparam logic [1:0] MODE_L1  = 2'd0;
    localparam logic [1:0] MODE_L2  = 2'd1;
    localparam logic [1:0] MODE_MAX = 2'd2;

    localparam logic [1:0] MODE_RESET = MODE_L2;

    // sideband that travels with every pixel pair down the pipe
    typedef struct packed {
        logic [1:0] mode;
        logic       last;
    } t_side;

endpackage

// ===== sv/gmu_front.sv =====
// Front end: squares both pixels, forms sum/max, then sums the squares.
// Two register stages with per-stage handshake. Depends on gmu_pkg.
module gmu_front import gmu_pkg::*; #(
    parameter int PIX_BITS = 8,
    parameter int RAD_W    = 2 * PIX_BITS + 2
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [PIX_BITS-1:0] i_x,
    input  logic [PIX_BITS-1:0] i_y,
    input  t_side               i_side,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [RAD_W-1:0]    o_rad,
    output logic [PIX_BITS:0]   o_lin,
    output t_side               o_side
);

    localparam int SQ_W = 2 * PIX_BITS;

    logic                r_v1;
    logic [SQ_W-1:0]     r_sq_x;
    logic [SQ_W-1:0]     r_sq_y;
    logic [PIX_BITS:0]   r_lin1;
    t_side               r_side1;
    logic [SQ_W-1:0]     n_sq_x;
    logic [SQ_W-1:0]     n_sq_y;
    logic [PIX_BITS:0]   n_lin1;
    logic                w_rdy1;

    logic                r_v2;
    logic [RAD_W-1:0]    r_rad;
    logic [PIX_BITS:0]   r_lin2;
    t_side               r_side2;
    logic [RAD_W-1:0]    n_rad;

    assign w_rdy1  = !r_v2 || i_ready;
    assign o_ready = !r_v1 || w_rdy1;

    always_comb begin
        n_sq_x = SQ_W'(i_x) * SQ_W'(i_x);
        n_sq_y = SQ_W'(i_y) * SQ_W'(i_y);
        if (i_side.mode == MODE_MAX) begin
            n_lin1 = (i_x > i_y) ? {1'b0, i_x} : {1'b0, i_y};
        end else begin
            n_lin1 = {1'b0, i_x} + {1'b0, i_y};
        end
    end

    assign n_rad = RAD_W'(r_sq_x) + RAD_W'(r_sq_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (o_ready) begin
            r_v1 <= i_valid;
        end
        if (o_ready) begin
            r_sq_x  <= n_sq_x;
            r_sq_y  <= n_sq_y;
            r_lin1  <= n_lin1;
            r_side1 <= i_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_rdy1) begin
            r_v2 <= r_v1;
        end
        if (w_rdy1) begin
            r_rad   <= n_rad;
            r_lin2  <= r_lin1;
            r_side2 <= r_side1;
        end
    end

    assign o_valid = r_v2;
    assign o_rad   = r_rad;
    assign o_lin   = r_lin2;
    assign o_side  = r_side2;

endmodule

// ===== sv/gmu_root_step.sv =====
// One registered step of the digit-by-digit floor square root.
// Resolves one root bit per stage. Depends on gmu_pkg.
module gmu_root_step import gmu_pkg::*; #(
    parameter int RAD_W = 18,
    parameter int LIN_W = 9,
    parameter int STEP  = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [RAD_W-1:0] i_rem,
    input  logic [RAD_W-1:0] i_root,
    input  logic [LIN_W-1:0] i_lin,
    input  t_side            i_side,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [RAD_W-1:0] o_rem,
    output logic [RAD_W-1:0] o_root,
    output logic [LIN_W-1:0] o_lin,
    output t_side            o_side
);

    localparam logic [RAD_W-1:0] BIT = RAD_W'(1) << (2 * STEP);

    logic             r_valid;
    logic [RAD_W-1:0] r_rem;
    logic [RAD_W-1:0] r_root;
    logic [LIN_W-1:0] r_lin;
    t_side            r_side;
    logic [RAD_W-1:0] n_rem;
    logic [RAD_W-1:0] n_root;
    logic [RAD_W-1:0] w_trial;

    assign o_ready = !r_valid || i_ready;
    assign w_trial = i_root + BIT;

    always_comb begin
        if (i_rem >= w_trial) begin
            n_rem  = i_rem - w_trial;
            n_root = (i_root >> 1) + BIT;
        end else begin
            n_rem  = i_rem;
            n_root = i_root >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready) begin
            r_rem  <= n_rem;
            r_root <= n_root;
            r_lin  <= i_lin;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_root  = r_root;
    assign o_lin   = r_lin;
    assign o_side  = r_side;

endmodule

// ===== sv/gmu_out.sv =====
// Output stage: picks the norm, saturates, holds the result beat.
// Depends on gmu_pkg.
module gmu_out import gmu_pkg::*; #(
    parameter int PIX_BITS = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [PIX_BITS:0]   i_root,
    input  logic [PIX_BITS:0]   i_lin,
    input  t_side               i_side,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [PIX_BITS-1:0] o_mag,
    output logic                o_over,
    output logic                o_last
);

    logic                r_valid;
    logic [PIX_BITS-1:0] r_mag;
    logic                r_over;
    logic                r_last;
    logic [PIX_BITS:0]   w_full;
    logic [PIX_BITS-1:0] n_mag;

    assign o_ready = !r_valid || i_ready;

    // unused code 3 falls through to L2
    assign w_full = (i_side.mode == MODE_L1 || i_side.mode == MODE_MAX) ? i_lin : i_root;
    // both norms stay below 2^(PIX_BITS+1), so the top bit is the overflow
    assign n_mag  = w_full[PIX_BITS] ? {PIX_BITS{1'b1}} : w_full[PIX_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready) begin
            r_mag  <= n_mag;
            r_over <= w_full[PIX_BITS];
            r_last <= i_side.last;
        end
    end

    assign o_valid = r_valid;
    assign o_mag   = r_mag;
    assign o_over  = r_over;
    assign o_last  = r_last;

endmodule

// ===== sv/gradient_magnitude_unifier_unit.sv =====
// Gradient magnitude unit: L1, L2 (floor sqrt) or max norm of two pixels.
// Pipeline: two front stages, one square-root stage per root bit, one output stage.
// Throughput: one beat per cycle; each stage has its own valid and holds on stall.
// Reset (synchronous, active low) empties the pipe and sets the norm to L2.
module gradient_magnitude_unifier_unit import gmu_pkg::*; #(
    parameter int  PIXEL_BITS = 8,
    localparam int IN_W       = ((2 * PIXEL_BITS + 7) / 8) * 8,
    localparam int OUT_W      = ((PIXEL_BITS + 7) / 8) * 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [IN_W-1:0]   i_s_tdata,   // x_value, y_value
    input  logic              i_s_tlast,   // last_pixel
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [OUT_W-1:0]  o_m_tdata,   // magnitude
    output logic [0:0]        o_m_tuser,   // overflow
    output logic              o_m_tlast,   // last_out
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_data
);

    localparam int RAD_W = 2 * PIXEL_BITS + 2;
    localparam int NSTEP = RAD_W / 2;
    localparam int LIN_W = PIXEL_BITS + 1;

    logic [1:0]          r_norm_mode;
    t_side               w_in_side;

    logic [NSTEP:0]      w_valid;
    logic [NSTEP:0]      w_ready;
    logic [RAD_W-1:0]    w_rem  [0:NSTEP];
    logic [RAD_W-1:0]    w_root [0:NSTEP];
    logic [LIN_W-1:0]    w_lin  [0:NSTEP];
    t_side               w_side [0:NSTEP];
    logic [PIXEL_BITS-1:0] w_mag;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_norm_mode <= MODE_RESET;
        end else if (i_cfg_valid) begin
            r_norm_mode <= i_cfg_data;
        end
    end

    assign w_in_side.mode = r_norm_mode;
    assign w_in_side.last = i_s_tlast;

    gmu_front #(
        .PIX_BITS (PIXEL_BITS),
        .RAD_W    (RAD_W)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_x     (i_s_tdata[PIXEL_BITS-1:0]),
        .i_y     (i_s_tdata[2*PIXEL_BITS-1:PIXEL_BITS]),
        .i_side  (w_in_side),
        .o_valid (w_valid[0]),
        .i_ready (w_ready[0]),
        .o_rad   (w_rem[0]),
        .o_lin   (w_lin[0]),
        .o_side  (w_side[0])
    );

    assign w_root[0] = '0;

    // root bits resolved from the top down
    for (genvar k = 0; k < NSTEP; k++) begin : g_root
        gmu_root_step #(
            .RAD_W (RAD_W),
            .LIN_W (LIN_W),
            .STEP  (NSTEP - 1 - k)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[k]),
            .o_ready (w_ready[k]),
            .i_rem   (w_rem[k]),
            .i_root  (w_root[k]),
            .i_lin   (w_lin[k]),
            .i_side  (w_side[k]),
            .o_valid (w_valid[k+1]),
            .i_ready (w_ready[k+1]),
            .o_rem   (w_rem[k+1]),
            .o_root  (w_root[k+1]),
            .o_lin   (w_lin[k+1]),
            .o_side  (w_side[k+1])
        );
    end

    gmu_out #(
        .PIX_BITS (PIXEL_BITS)
    ) u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid[NSTEP]),
        .o_ready (w_ready[NSTEP]),
        .i_root  (w_root[NSTEP][PIXEL_BITS:0]),
        .i_lin   (w_lin[NSTEP]),
        .i_side  (w_side[NSTEP]),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_mag   (w_mag),
        .o_over  (o_m_tuser[0]),
        .o_last  (o_m_tlast)
    );

    assign o_m_tdata = OUT_W'(w_mag);

`ifndef SYNTHESIS
    // an overflowing norm must show as full scale
    a_sat_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0]) |-> (w_mag == {PIXEL_BITS{1'b1}}))
        else $error("overflow beat without saturated magnitude");

    // backpressure at the input only when a result is stuck at the output
    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> o_m_tvalid)
        else $error("input stalled while output is empty");

    // the norm leaves reset as L2
    a_mode_rst: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> (r_norm_mode == MODE_L2))
        else $error("norm mode not L2 after reset");

    // root register never grows beyond PIXEL_BITS+1 bits at the last step
    a_root_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_valid[NSTEP] |-> ((w_root[NSTEP] >> LIN_W) == '0))
        else $error("square root out of range");
`endif

endmodule

// ===== test/gmu_stream_checker.sv =====
`timescale 1ns / 1ps
// Stream checker for the gradient magnitude unit: watches the pixel, result
// and norm-register channels, predicts each result and compares it.
// Depends on gmu_pkg for the norm selector codes.
module gmu_stream_checker import gmu_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [15:0] i_s_tdata,    // x_value, y_value
    input  logic        i_s_tlast,    // last_pixel
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [7:0]  i_m_tdata,    // magnitude
    input  logic [0:0]  i_m_tuser,    // overflow
    input  logic        i_m_tlast,    // last_out
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_data,
    output logic [31:0] o_fail_count,
    output logic [31:0] o_pending,
    output logic [31:0] o_checked,
    output logic [31:0] o_saturated
);

    localparam int PRINT_CAP = 50;

    typedef struct packed {
        logic [7:0] magnitude;
        logic       overflow;
        logic       last_out;
    } t_pix_result;

    t_pix_result expected_mags[$];
    logic [1:0]  norm_sel;
    int unsigned fail_count;
    int unsigned checked;
    int unsigned saturated;

    assign o_fail_count = fail_count;
    assign o_pending    = expected_mags.size();
    assign o_checked    = checked;
    assign o_saturated  = saturated;

    // bit-serial floor square root, 17-bit operand -> 9-bit root
    function automatic logic [8:0] floor_root(logic [16:0] v);
        logic [8:0]  root;
        logic [8:0]  trial;
        logic [17:0] trial_sq;
        root = '0;
        for (int b = 8; b >= 0; b--) begin
            trial    = root | (9'd1 << b);
            trial_sq = trial * trial;
            if (trial_sq <= {1'b0, v}) begin
                root = trial;
            end
        end
        return root;
    endfunction

    function automatic t_pix_result predict_magnitude(logic [1:0] sel, logic [7:0] x,
                                                      logic [7:0] y, logic last);
        logic [16:0] sum_sq;
        logic [9:0]  norm;
        t_pix_result r;
        sum_sq = x * x + y * y;
        case (sel)
            MODE_L1:  norm = x + y;
            MODE_MAX: norm = (x > y) ? x : y;
            default:  norm = floor_root(sum_sq);   // L2, and the spare code
        endcase
        r.overflow  = (norm > 10'd255);
        r.magnitude = r.overflow ? 8'hFF : norm[7:0];
        r.last_out  = last;
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        if (fail_count < PRINT_CAP) begin
            $display("check: %s", msg);
        end
        fail_count++;
    endtask

    initial begin
        fail_count = 0;
        checked    = 0;
        saturated  = 0;
        norm_sel   = MODE_RESET;
    end

    always @(posedge i_clk) begin
        t_pix_result want;
        if (!i_rst_n) begin
            expected_mags.delete();
            norm_sel = MODE_RESET;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (expected_mags.size() == 0) begin
                    report_mismatch($sformatf("result beat with nothing pending: mag %0d",
                                              i_m_tdata));
                end else begin
                    want = expected_mags.pop_front();
                    if (i_m_tdata !== want.magnitude)
                        report_mismatch($sformatf("result %0d magnitude: expected %0d, got %0d",
                                                  checked, want.magnitude, i_m_tdata));
                    if (i_m_tuser[0] !== want.overflow)
                        report_mismatch($sformatf("result %0d overflow: expected %0b, got %0b",
                                                  checked, want.overflow, i_m_tuser[0]));
                    if (i_m_tlast !== want.last_out)
                        report_mismatch($sformatf("result %0d last: expected %0b, got %0b",
                                                  checked, want.last_out, i_m_tlast));
                    if (want.overflow)
                        saturated++;
                    checked++;
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                expected_mags.push_back(predict_magnitude(norm_sel, i_s_tdata[7:0],
                                                          i_s_tdata[15:8], i_s_tlast));
            end
            if (i_cfg_valid && i_cfg_ready) begin
                norm_sel = i_cfg_data;
            end
        end
    end

endmodule

// ===== test/gradient_magnitude_unifier_unit_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for gradient_magnitude_unifier_unit: bursty pixel stimulus,
// stalling result sink, norm register writes between phases, verdict.
// Depends on gmu_pkg, the block, and gmu_stream_checker.
module gradient_magnitude_unifier_unit_tb import gmu_pkg::*; ();

    localparam logic [1:0]  MODE_SPARE   = 2'd3;   // unused code, acts as L2
    localparam int          PHASE_ITEMS  = 262;
    localparam int          HOLD_CYCLES  = 80;
    localparam int          DRAIN_CYCLES = 40;
    localparam int          LIMIT_CYCLES = 300000;
    localparam int          NUM_PHASES   = 6;
    localparam logic [1:0]  NORM_PLAN [NUM_PHASES] =
        '{MODE_L1, MODE_MAX, MODE_SPARE, MODE_L2, MODE_L1, MODE_MAX};
    localparam int          NUM_EDGE     = 16;
    localparam logic [7:0]  EDGE_X [NUM_EDGE] =
        '{8'd0, 8'd255, 8'd255, 8'd0, 8'd1, 8'd3, 8'd180, 8'd181,
          8'd181, 8'd128, 8'd128, 8'd170, 8'd85, 8'd254, 8'd1, 8'd255};
    localparam logic [7:0]  EDGE_Y [NUM_EDGE] =
        '{8'd0, 8'd255, 8'd0, 8'd255, 8'd1, 8'd4, 8'd180, 8'd181,
          8'd182, 8'd127, 8'd128, 8'd85, 8'd170, 8'd1, 8'd254, 8'd254};
    localparam logic [7:0]  CORNERS [6] = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd254, 8'd255};

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;
    logic [0:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_data  = '0;

    logic        s_beat    = 1'b0;
    logic        cfg_beat  = 1'b0;
    logic [31:0] fail_count;
    logic [31:0] pending;
    logic [31:0] checked;
    logic [31:0] saturated;
    int unsigned pairs_sent = 0;
    int unsigned holds_done = 0;

    always #5 clk = ~clk;

    gradient_magnitude_unifier_unit #(.PIXEL_BITS(8)) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tlast   (s_tlast),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser),
        .o_m_tlast   (m_tlast),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    gmu_stream_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tlast    (s_tlast),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_m_tlast    (m_tlast),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_saturated  (saturated)
    );

    // handshake seen at the last rising edge, read back at the falling edge
    always @(posedge clk) begin
        s_beat   <= s_tvalid && s_tready;
        cfg_beat <= cfg_valid && cfg_ready;
    end

    function automatic logic [7:0] pick_pixel(bit corner);
        if (corner)
            return CORNERS[$urandom_range(0, 5)];
        return 8'($urandom_range(0, 255));
    endfunction

    // called at a falling edge; returns at the falling edge after the beat
    task automatic send_pixel(logic [7:0] x, logic [7:0] y, logic last);
        s_tvalid <= 1'b1;
        s_tdata  <= {y, x};
        s_tlast  <= last;
        do @(negedge clk); while (!s_beat);
        pairs_sent++;
    endtask

    task automatic send_random_pairs(int unsigned count);
        int unsigned left;
        int unsigned burst;
        int unsigned gap;
        bit          corner;
        left = count;
        while (left > 0) begin
            burst = $urandom_range(1, 24);
            for (int i = 0; i < burst && left > 0; i++) begin
                corner = ($urandom_range(0, 5) == 0);
                send_pixel(pick_pixel(corner), pick_pixel(corner),
                           $urandom_range(0, 15) == 0);
                left--;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending != 0) @(negedge clk);
    endtask

    task automatic write_norm(logic [1:0] sel);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= sel;
        do @(negedge clk); while (!cfg_beat);
        cfg_valid <= 1'b0;
    endtask

    // result sink: random stall patterns, plus long hold-offs that back up the pipe
    initial begin : result_sink
        int unsigned kind;
        int unsigned span;
        int unsigned next_hold;
        next_hold = 400;
        @(posedge rst_n);
        forever begin
            kind = $urandom_range(0, 3);
            span = $urandom_range(1, 40);
            for (int i = 0; i < span; i++) begin
                @(negedge clk);
                if (checked >= next_hold) begin
                    m_tready <= 1'b0;
                    for (int h = 0; h < HOLD_CYCLES; h++) @(negedge clk);
                    holds_done++;
                    next_hold += 900;
                end
                case (kind)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    2:       m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= i[0];
                endcase
            end
        end
    end

    initial begin : watchdog
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("tb: timeout after %0d cycles, %0d results pending", LIMIT_CYCLES, pending);
        $display("tb: failure");
        $finish;
    end

    initial begin : stimulus
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // edge pairs under the reset norm (L2), last marker on a few
        for (int i = 0; i < NUM_EDGE; i++)
            send_pixel(EDGE_X[i], EDGE_Y[i], i[1:0] == 2'b11);
        s_tvalid <= 1'b0;
        send_random_pairs(PHASE_ITEMS);

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_norm(NORM_PLAN[p]);
            send_random_pairs(PHASE_ITEMS);
        end

        wait_drained();
        for (int i = 0; i < DRAIN_CYCLES; i++) @(negedge clk);

        $display("run: %0d pixel pairs under L2 reset, L1, max and the spare norm code",
                 pairs_sent);
        $display("run: %0d results checked, %0d saturated, %0d long sink hold-offs",
                 checked, saturated, holds_done);
        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/gmu_pkg.sv
sv/gmu_front.sv
sv/gmu_root_step.sv
sv/gmu_out.sv
sv/gradient_magnitude_unifier_unit.sv
test/gmu_stream_checker.sv
test/gradient_magnitude_unifier_unit_tb.sv
